@@ rtl/sidta_pkg.sv @@
// Shared constants and types for the signed integer to decimal text converter.
`default_nettype none

package sidta_pkg;

    // ASCII codes of the characters the block can emit
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;
    localparam logic [7:0] DIGIT_MAX   = 8'd9;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CONV,
        BK_SCAN,
        BK_SIGN,
        BK_DIGIT
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/signed_int_to_decimal_ascii.sv @@
// Top level of the signed integer to decimal ASCII text converter.
`default_nettype none

// Each input transaction carries one signed VALUE_WIDTH-bit integer; the block answers
// with its decimal text, most significant digit first, as one output transaction per
// character: a leading '-' for negative values, a single '0' for zero, and tlast on the
// final digit. The most negative value prints in full. A front stage splits off the
// sign and magnitude and hands it through a two-entry queue to the converter, so the
// next value is taken while the current one is still being printed. The converter
// loads the value, spends VALUE_WIDTH shift-and-add-3 steps and one digit-scan step,
// then emits one character per cycle while the output is not stalled.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,   // value, zero padded above
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [7:0]                               m_tdata,   // char_code
    output logic                                     m_tlast    // last_char
);

    logic                 front_valid;
    logic                 front_ready;
    logic [VALUE_WIDTH:0] front_data;
    logic                 q_valid;
    logic                 q_ready;
    logic [VALUE_WIDTH:0] q_data;

    sidta_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata[VALUE_WIDTH-1:0]),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    sidta_queue #(
        .DATA_W (VALUE_WIDTH + 1)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    sidta_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_data   (q_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

`ifndef SYNTHESIS
    // Every emitted character is a minus sign or a decimal digit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == sidta_pkg::ASCII_MINUS ||
                      (m_tdata >= sidta_pkg::ASCII_ZERO &&
                       m_tdata <= sidta_pkg::ASCII_ZERO + sidta_pkg::DIGIT_MAX)))
        else $error("output character outside '-' and '0'..'9'");

    // A sign is always followed by at least one digit
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata == sidta_pkg::ASCII_MINUS) |-> !m_tlast)
        else $error("minus sign marked as last character");

    // The front stage must stop taking input while its item waits on a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (front_valid && !front_ready) |-> !s_tready)
        else $error("input accepted while front stage is blocked");
`endif

endmodule

`default_nettype wire

@@ rtl/sidta_front.sv @@
// Front end: accepts a value, splits it into sign and unsigned magnitude.
`default_nettype none

module sidta_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [VALUE_WIDTH-1:0] in_value,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [VALUE_WIDTH:0]        out_data    // {neg, magnitude}
);

    logic                   valid_reg;
    logic                   valid_next;
    logic [VALUE_WIDTH:0]   data_reg;
    logic [VALUE_WIDTH:0]   data_next;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   accept;

    // Classify the sign and form the magnitude; the most negative value maps to 2^(W-1)
    assign neg = in_value[VALUE_WIDTH-1];
    assign mag = neg ? (~in_value + VALUE_WIDTH'(1)) : in_value;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Hold the classified item until the queue takes it
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            data_next  = {neg, mag};
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ rtl/sidta_queue.sv @@
// Two-entry queue between the front end and the conversion back end.
`default_nettype none

module sidta_queue #(
    parameter int DATA_W = 33
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      out_data
);

    logic [DATA_W-1:0] mem [0:1];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the incoming entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sidta_back.sv @@
// Back end: shift-and-add-3 binary to BCD conversion and character emission.
`default_nettype none

module sidta_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [VALUE_WIDTH:0] in_data,     // {neg, magnitude}
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                out_char,
    output logic                      out_last
);

    // Decimal digits needed for 2^W - 1: floor(W * log10(2)) + 1
    localparam int NDIG    = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int DIDX_W  = $clog2(NDIG);
    localparam int CNT_W   = $clog2(VALUE_WIDTH);

    sidta_pkg::back_state_t state_reg;
    sidta_pkg::back_state_t state_next;

    logic [VALUE_WIDTH-1:0]  shift_reg;
    logic [VALUE_WIDTH-1:0]  shift_next;
    logic [NDIG-1:0][3:0]    bcd_reg;
    logic [NDIG-1:0][3:0]    bcd_next;
    logic                    neg_reg;
    logic                    neg_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic [DIDX_W-1:0]       idx_reg;
    logic [DIDX_W-1:0]       idx_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [7:0]              out_char_reg;
    logic [7:0]              out_char_next;
    logic                    out_last_reg;
    logic                    out_last_next;

    logic [NDIG-1:0][3:0]    bcd_adj;
    logic [NDIG*4:0]         bcd_wide;
    logic [DIDX_W-1:0]       lead_idx;
    logic                    slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == sidta_pkg::BK_IDLE);

    // Add 3 to every digit of 5 or more, then shift in the next magnitude bit
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? (bcd_reg[i] + 4'd3) : bcd_reg[i];
        end
        bcd_wide = {bcd_adj, shift_reg[VALUE_WIDTH-1]};
    end

    // Locate the most significant nonzero digit (zero prints as one digit)
    always_comb
    begin
        lead_idx = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                lead_idx = DIDX_W'(i);
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sidta_pkg::BK_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sidta_pkg::BK_CONV;
                end
            end
            sidta_pkg::BK_CONV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = sidta_pkg::BK_SCAN;
                end
            end
            sidta_pkg::BK_SCAN:
            begin
                state_next = neg_reg ? sidta_pkg::BK_SIGN : sidta_pkg::BK_DIGIT;
            end
            sidta_pkg::BK_SIGN:
            begin
                if (slot_free)
                begin
                    state_next = sidta_pkg::BK_DIGIT;
                end
            end
            sidta_pkg::BK_DIGIT:
            begin
                if (slot_free && (idx_reg == '0))
                begin
                    state_next = sidta_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = sidta_pkg::BK_IDLE;
            end
        endcase
    end

    // Datapath and output register updates
    always_comb
    begin
        shift_next     = shift_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            sidta_pkg::BK_IDLE:
            begin
                if (in_valid)
                begin
                    shift_next = in_data[VALUE_WIDTH-1:0];
                    neg_next   = in_data[VALUE_WIDTH];
                    bcd_next   = '0;
                    cnt_next   = CNT_W'(VALUE_WIDTH - 1);
                end
            end
            sidta_pkg::BK_CONV:
            begin
                shift_next = shift_reg << 1;
                bcd_next   = bcd_wide[NDIG*4-1:0];
                cnt_next   = cnt_reg - CNT_W'(1);
            end
            sidta_pkg::BK_SCAN:
            begin
                idx_next = lead_idx;
            end
            sidta_pkg::BK_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = sidta_pkg::ASCII_MINUS;
                    out_last_next  = 1'b0;
                end
            end
            sidta_pkg::BK_DIGIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = sidta_pkg::ASCII_ZERO + {4'd0, bcd_reg[idx_reg]};
                    out_last_next  = (idx_reg == '0);
                    idx_next       = idx_reg - DIDX_W'(1);
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sidta_pkg::BK_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        bcd_reg      <= bcd_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire
